@@ hw/rtl/c2e_pkg.sv @@
// Package for the calendar to epoch seconds block: types, constants and helper functions.
`timescale 1ns / 1ps

package c2e_pkg;

   localparam int YearWidth    = 14;
   localparam int FullYearWidth = 13;
   localparam int MonthWidth   = 4;
   localparam int DayWidth     = 5;
   localparam int HourWidth    = 5;
   localparam int MinuteWidth  = 6;
   localparam int SecondWidth  = 6;
   localparam int EpochWidth   = 39;
   localparam int DaysWidth    = 23;
   localparam int TodWidth     = 17;
   localparam int LeapCntWidth = 14;
   localparam int QuotWidth    = 7;

   localparam int QueueDepth   = 2;
   localparam int PtrWidth     = $clog2(QueueDepth);
   localparam int CountWidth   = $clog2(QueueDepth + 1);

   localparam logic [FullYearWidth-1:0] BaseYear  = 13'd1900;
   localparam logic [13:0] Year1970 = 14'd1970;
   localparam logic [13:0] Year1969 = 14'd1969;
   localparam logic [13:0] Year1901 = 14'd1901;
   localparam logic [13:0] Year1601 = 14'd1601;
   localparam logic [12:0] Recip100 = 13'd5243;
   localparam int          Recip100Shift = 19;

   localparam logic [MonthWidth-1:0] MonthJan = 4'd0;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd1;
   localparam logic [MonthWidth-1:0] MonthMar = 4'd2;
   localparam logic [MonthWidth-1:0] MonthApr = 4'd3;
   localparam logic [MonthWidth-1:0] MonthMay = 4'd4;
   localparam logic [MonthWidth-1:0] MonthJun = 4'd5;
   localparam logic [MonthWidth-1:0] MonthJul = 4'd6;
   localparam logic [MonthWidth-1:0] MonthAug = 4'd7;
   localparam logic [MonthWidth-1:0] MonthSep = 4'd8;
   localparam logic [MonthWidth-1:0] MonthOct = 4'd9;
   localparam logic [MonthWidth-1:0] MonthNov = 4'd10;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd11;

   localparam logic [HourWidth-1:0]   MaxHour   = 5'd23;
   localparam logic [MinuteWidth-1:0] MaxMinute = 6'd59;
   localparam logic [SecondWidth-1:0] MaxSecond = 6'd60;

   typedef struct packed {
      logic                     ok;
      logic [FullYearWidth-1:0] year;
      logic                     leap;
      logic [MonthWidth-1:0]    month;
      logic [DayWidth-1:0]      mday;
      logic [HourWidth-1:0]     hour;
      logic [MinuteWidth-1:0]   minute;
      logic [SecondWidth-1:0]   second;
   } entry_type;

   function automatic logic [QuotWidth-1:0] div100(input logic [FullYearWidth-1:0] n);
      logic [25:0] prod;
      prod = 26'(n) * 26'(Recip100);
      return prod[Recip100Shift +: QuotWidth];
   endfunction

   function automatic logic [DayWidth-1:0] month_length(input logic [MonthWidth-1:0] mon,
                                                        input logic leap);
      case (mon)
         MonthFeb: month_length = leap ? 5'd29 : 5'd28;
         MonthApr, MonthJun, MonthSep, MonthNov: month_length = 5'd30;
         default: month_length = 5'd31;
      endcase
   endfunction

   function automatic logic [8:0] days_before_month(input logic [MonthWidth-1:0] mon);
      case (mon)
         MonthJan: days_before_month = 9'd0;
         MonthFeb: days_before_month = 9'd31;
         MonthMar: days_before_month = 9'd59;
         MonthApr: days_before_month = 9'd90;
         MonthMay: days_before_month = 9'd120;
         MonthJun: days_before_month = 9'd151;
         MonthJul: days_before_month = 9'd181;
         MonthAug: days_before_month = 9'd212;
         MonthSep: days_before_month = 9'd243;
         MonthOct: days_before_month = 9'd273;
         MonthNov: days_before_month = 9'd304;
         MonthDec: days_before_month = 9'd334;
         default: days_before_month = 9'd0;
      endcase
   endfunction

endpackage

@@ hw/rtl/c2e_front.sv @@
// Front stage: accepts request words, resolves the full year and checks every field.
`timescale 1ns / 1ps

module c2e_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [c2e_pkg::YearWidth-1:0] req_year_value,
   input  logic [c2e_pkg::MonthWidth-1:0]  req_month_index,
   input  logic [c2e_pkg::DayWidth-1:0]    req_day_of_month,
   input  logic [c2e_pkg::HourWidth-1:0]   req_hour_value,
   input  logic [c2e_pkg::MinuteWidth-1:0] req_minute_value,
   input  logic [c2e_pkg::SecondWidth-1:0] req_second_value,
   input  logic                            queue_full,
   output logic                            busy,
   output logic                            push,
   output c2e_pkg::entry_type              push_entry
);

   logic                              front_vld_ff, front_vld_in;
   c2e_pkg::entry_type                front_ff, front_in;
   logic [c2e_pkg::FullYearWidth-1:0] year_low;
   logic [c2e_pkg::FullYearWidth-1:0] full_year;
   logic [c2e_pkg::QuotWidth-1:0]     quot_cur, quot_prev;
   logic                              leap;
   logic                              accept;

   assign busy   = front_vld_ff && queue_full;
   assign push   = front_vld_ff && !queue_full;
   assign accept = start && !busy;
   assign push_entry = front_ff;

   always_comb begin
      year_low  = req_year_value[c2e_pkg::FullYearWidth-1:0];
      full_year = (year_low < c2e_pkg::BaseYear) ? year_low + c2e_pkg::BaseYear : year_low;
      quot_cur  = c2e_pkg::div100(full_year);
      quot_prev = c2e_pkg::div100(full_year - 13'd1);
      leap = (full_year[1:0] == 2'b00) &&
             ((quot_cur == quot_prev) || (quot_cur[1:0] == 2'b00));

      front_in.year   = full_year;
      front_in.leap   = leap;
      front_in.month  = req_month_index;
      front_in.mday   = req_day_of_month;
      front_in.hour   = req_hour_value;
      front_in.minute = req_minute_value;
      front_in.second = req_second_value;
      front_in.ok = !req_year_value[c2e_pkg::YearWidth-1] &&
                    (req_month_index <= c2e_pkg::MonthDec) &&
                    (req_day_of_month != 5'd0) &&
                    (req_day_of_month <= c2e_pkg::month_length(req_month_index, leap)) &&
                    (req_hour_value <= c2e_pkg::MaxHour) &&
                    (req_minute_value <= c2e_pkg::MaxMinute) &&
                    (req_second_value <= c2e_pkg::MaxSecond);

      front_vld_in = accept || (front_vld_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff <= front_in;
      end
   end

endmodule

@@ hw/rtl/c2e_queue.sv @@
// Short queue of checked words between the front and back stages.
`timescale 1ns / 1ps

module c2e_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  c2e_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output c2e_pkg::entry_type head_entry
);

   c2e_pkg::entry_type               slot_ff [c2e_pkg::QueueDepth];
   logic [c2e_pkg::PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [c2e_pkg::PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [c2e_pkg::CountWidth-1:0]   count_ff, count_in;
   logic                             do_pop;

   assign full       = (count_ff == c2e_pkg::CountWidth'(c2e_pkg::QueueDepth));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == c2e_pkg::PtrWidth'(c2e_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == c2e_pkg::PtrWidth'(c2e_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/c2e_back.sv @@
// Back pipeline: leap day count, day number, and scaling to seconds.
`timescale 1ns / 1ps

module c2e_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     not_empty,
   input  c2e_pkg::entry_type                       head_entry,
   output logic                                     pop,
   output logic                                     rsp_strobe,
   output logic signed [c2e_pkg::EpochWidth-1:0]    rsp_epoch_seconds,
   output logic                                     rsp_valid_res
);

   // stage one
   logic                                         s1_vld_ff;
   logic                                         s1_ok_ff;
   logic signed [c2e_pkg::DaysWidth-1:0]         s1_base_ff, s1_base_in;
   logic signed [c2e_pkg::LeapCntWidth-1:0]      s1_lcnt_ff, s1_lcnt_in;
   logic                                         s1_leap_ff;
   logic [c2e_pkg::MonthWidth-1:0]               s1_month_ff;
   logic [c2e_pkg::DayWidth-1:0]                 s1_mday_ff;
   logic [c2e_pkg::HourWidth-1:0]                s1_hour_ff;
   logic [c2e_pkg::MinuteWidth-1:0]              s1_minute_ff;
   logic [c2e_pkg::SecondWidth-1:0]              s1_second_ff;
   // stage two
   logic                                         s2_vld_ff;
   logic                                         s2_ok_ff;
   logic signed [c2e_pkg::DaysWidth-1:0]         s2_days_ff, s2_days_in;
   logic [c2e_pkg::TodWidth-1:0]                 s2_tod_ff, s2_tod_in;
   // output
   logic                                         out_strobe_ff;
   logic signed [c2e_pkg::EpochWidth-1:0]        out_epoch_ff, out_epoch_in;
   logic                                         out_valid_ff;

   logic signed [13:0]                           yr_since_1970, yr_since_1969;
   logic signed [13:0]                           yr_since_1901;
   logic [13:0]                                  yr_since_1601;
   logic [13:0]                                  mag_1969, quarter_1969;
   logic signed [13:0]                           term4;
   logic [c2e_pkg::QuotWidth-1:0]                term100, term400;
   logic [c2e_pkg::FullYearWidth-1:0]            quarter_1601;
   logic                                         leap_adj;
   logic signed [c2e_pkg::EpochWidth-1:0]        sec_prod;

   assign pop = not_empty;

   always_comb begin
      yr_since_1970 = $signed({1'b0, head_entry.year} - c2e_pkg::Year1970);
      yr_since_1969 = $signed({1'b0, head_entry.year} - c2e_pkg::Year1969);
      yr_since_1901 = $signed({1'b0, head_entry.year} - c2e_pkg::Year1901);
      yr_since_1601 = {1'b0, head_entry.year} - c2e_pkg::Year1601;

      mag_1969     = yr_since_1969[13] ? 14'(-yr_since_1969) : 14'(yr_since_1969);
      quarter_1969 = mag_1969 >> 2;
      term4        = yr_since_1969[13] ? $signed(-quarter_1969) : $signed(quarter_1969);

      term100 = yr_since_1901[13] ? '0 :
                c2e_pkg::div100(yr_since_1901[c2e_pkg::FullYearWidth-1:0]);
      quarter_1601 = c2e_pkg::FullYearWidth'(yr_since_1601 >> 2);
      term400 = c2e_pkg::div100(quarter_1601);

      s1_lcnt_in = term4 - $signed({7'b0, term100}) + $signed({7'b0, term400});
      s1_base_in = c2e_pkg::DaysWidth'(yr_since_1970) * 23'sd365;
   end

   always_comb begin
      leap_adj   = (s1_month_ff >= c2e_pkg::MonthMar) && s1_leap_ff;
      s2_days_in = s1_base_ff
                 + c2e_pkg::DaysWidth'(s1_lcnt_ff)
                 + $signed({14'b0, c2e_pkg::days_before_month(s1_month_ff)})
                 + $signed({22'b0, leap_adj})
                 + $signed({18'b0, s1_mday_ff})
                 - 23'sd1;
      s2_tod_in = 17'(s1_hour_ff) * 17'd3600
                + 17'(s1_minute_ff) * 17'd60
                + 17'(s1_second_ff);
   end

   always_comb begin
      sec_prod = c2e_pkg::EpochWidth'(s2_days_ff) * 39'sd86400;
      out_epoch_in = s2_ok_ff ? sec_prod + $signed({22'b0, s2_tod_ff}) : '1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         s1_vld_ff     <= not_empty;
         s2_vld_ff     <= s1_vld_ff;
         out_strobe_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (not_empty) begin
         s1_ok_ff     <= head_entry.ok;
         s1_base_ff   <= s1_base_in;
         s1_lcnt_ff   <= s1_lcnt_in;
         s1_leap_ff   <= head_entry.leap;
         s1_month_ff  <= head_entry.month;
         s1_mday_ff   <= head_entry.mday;
         s1_hour_ff   <= head_entry.hour;
         s1_minute_ff <= head_entry.minute;
         s1_second_ff <= head_entry.second;
      end
      if (s1_vld_ff) begin
         s2_ok_ff   <= s1_ok_ff;
         s2_days_ff <= s2_days_in;
         s2_tod_ff  <= s2_tod_in;
      end
      if (s2_vld_ff) begin
         out_epoch_ff <= out_epoch_in;
         out_valid_ff <= s2_ok_ff;
      end
   end

   assign rsp_strobe        = out_strobe_ff;
   assign rsp_epoch_seconds = out_epoch_ff;
   assign rsp_valid_res     = out_valid_ff;

endmodule

@@ hw/rtl/calendar_to_epoch_seconds.sv @@
// Top level of the calendar to epoch seconds converter.
`timescale 1ns / 1ps

// Converts a broken-down UTC date and time into signed seconds since
// 1970-01-01 with a valid flag; a rejected field gives -1 and valid low.
// One request word is taken per clock while busy is low, and each result
// word appears on the rsp ports with rsp_strobe high for one cycle after
// it passes the front check register, the two-word queue and the three
// back pipeline stages (leap-day count, day number, multiply by 86400).
// The back part drains the queue every cycle, so busy rises only if the
// queue is full.
// rsp_strobe cannot be held off; capture the result in that cycle.

module calendar_to_epoch_seconds (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [c2e_pkg::YearWidth-1:0]  req_year_value,
   input  logic [c2e_pkg::MonthWidth-1:0]        req_month_index,
   input  logic [c2e_pkg::DayWidth-1:0]          req_day_of_month,
   input  logic [c2e_pkg::HourWidth-1:0]         req_hour_value,
   input  logic [c2e_pkg::MinuteWidth-1:0]       req_minute_value,
   input  logic [c2e_pkg::SecondWidth-1:0]       req_second_value,
   output logic                                  rsp_strobe,
   output logic signed [c2e_pkg::EpochWidth-1:0] rsp_epoch_seconds,
   output logic                                  rsp_valid_res
);

   logic               push, queue_full, not_empty, pop;
   c2e_pkg::entry_type push_entry, head_entry;

   c2e_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_year_value   (req_year_value),
      .req_month_index  (req_month_index),
      .req_day_of_month (req_day_of_month),
      .req_hour_value   (req_hour_value),
      .req_minute_value (req_minute_value),
      .req_second_value (req_second_value),
      .queue_full       (queue_full),
      .busy             (busy),
      .push             (push),
      .push_entry       (push_entry)
   );

   c2e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (not_empty),
      .head_entry (head_entry)
   );

   c2e_back u_back (
      .clock             (clock),
      .reset             (reset),
      .not_empty         (not_empty),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_valid_res     (rsp_valid_res)
   );

endmodule
